@@ rtl/mie_pkg.sv @@
// ----------------------------------------------------------------------------
// mie_pkg: shared types and constants of the I-type/J-type execute block
// Opcode codes, stream word layouts and the stage record passed between the
// operand stage and the memory stage.
// ----------------------------------------------------------------------------
package mie_pkg;

  // Data memory size in words; must be a power of two.
  localparam int MEM_WORDS = 1024;
  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam int RF_DEPTH  = 32;
  localparam int RF_AW     = $clog2(RF_DEPTH);
  localparam int XLEN      = 32;
  localparam int MIDX_W    = 10;
  localparam int IN_W      = 64;
  localparam int OUT_W     = 120;

  localparam logic [5:0] OP_J     = 6'h02;
  localparam logic [5:0] OP_JAL   = 6'h03;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_BNE   = 6'h05;
  localparam logic [5:0] OP_BLEZ  = 6'h06;
  localparam logic [5:0] OP_BGTZ  = 6'h07;
  localparam logic [5:0] OP_ADDI  = 6'h08;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_SLTI  = 6'h0A;
  localparam logic [5:0] OP_SLTIU = 6'h0B;
  localparam logic [5:0] OP_ANDI  = 6'h0C;
  localparam logic [5:0] OP_ORI   = 6'h0D;
  localparam logic [5:0] OP_XORI  = 6'h0E;
  localparam logic [5:0] OP_LUI   = 6'h0F;
  localparam logic [5:0] OP_LB    = 6'h20;
  localparam logic [5:0] OP_LH    = 6'h21;
  localparam logic [5:0] OP_LWL   = 6'h22;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_LBU   = 6'h24;
  localparam logic [5:0] OP_LHU   = 6'h25;
  localparam logic [5:0] OP_LWR   = 6'h26;
  localparam logic [5:0] OP_SB    = 6'h28;
  localparam logic [5:0] OP_SH    = 6'h29;
  localparam logic [5:0] OP_SWL   = 6'h2A;
  localparam logic [5:0] OP_SW    = 6'h2B;
  localparam logic [5:0] OP_SWR   = 6'h2E;
  localparam logic [5:0] OP_LL    = 6'h30;
  localparam logic [5:0] OP_SC    = 6'h38;

  typedef struct packed {
    logic [XLEN-1:0] current_pc;
    logic [XLEN-1:0] instruction;
  } in_word_t;

  typedef struct packed {
    logic [4:0]        pad;
    logic              unknown_op;
    logic [XLEN-1:0]   mem_value;
    logic [MIDX_W-1:0] mem_word_index;
    logic              mem_write;
    logic [XLEN-1:0]   reg_value;
    logic [RF_AW-1:0]  reg_index;
    logic              reg_write;
    logic [XLEN-1:0]   branch_target;
    logic              branch_taken;
  } out_word_t;

  // Record of one instruction between operand stage and memory stage.
  typedef struct packed {
    logic              taken;
    logic [XLEN-1:0]   target;
    logic              wreg;
    logic              is_load;
    logic [RF_AW-1:0]  ridx;
    logic [XLEN-1:0]   rval;
    logic              wmem;
    logic              unknown;
    logic [5:0]        op;
    logic [1:0]        lane;
    logic [MEM_AW-1:0] widx;
    logic [XLEN-1:0]   b;
  } stage_t;

endpackage

@@ rtl/mie_ram.sv @@
// ----------------------------------------------------------------------------
// mie_ram: generic single-write, single-read synchronous RAM
// Read data is registered and holds while the read enable is low. A read of
// the address written at the same edge returns the old contents.
// ----------------------------------------------------------------------------
module mie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/mie_merge.sv @@
// ----------------------------------------------------------------------------
// mie_merge: load extraction and store byte merge
// Builds the register value of a load and the whole memory word of a store
// from the addressed memory word, the byte lane and the rt operand.
// ----------------------------------------------------------------------------
module mie_merge (
  input  logic [5:0]               op,
  input  logic [1:0]               lane,
  input  logic [mie_pkg::XLEN-1:0] w,
  input  logic [mie_pkg::XLEN-1:0] b,
  output logic [mie_pkg::XLEN-1:0] ld_val,
  output logic [mie_pkg::XLEN-1:0] st_val
);
  import mie_pkg::*;

  logic [4:0]      bsh;
  logic [4:0]      hsh;
  logic [7:0]      byte_v;
  logic [15:0]     half_v;

  assign bsh    = {lane, 3'b000};
  assign hsh    = {lane[1], 4'b0000};
  assign byte_v = 8'(w >> bsh);
  assign half_v = lane[1] ? w[31:16] : w[15:0];

  always_comb begin
    ld_val = w;
    st_val = b;
    case (op)
      OP_LB:  ld_val = {{24{byte_v[7]}}, byte_v};
      OP_LBU: ld_val = {24'h000000, byte_v};
      OP_LH:  ld_val = {{16{half_v[15]}}, half_v};
      OP_LHU: ld_val = {16'h0000, half_v};
      OP_LWL: begin
        case (lane)
          2'd0:    ld_val = {w[7:0], b[23:0]};
          2'd1:    ld_val = {w[15:0], b[15:0]};
          2'd2:    ld_val = {w[23:0], b[7:0]};
          default: ld_val = w;
        endcase
      end
      OP_LWR: begin
        case (lane)
          2'd0:    ld_val = w;
          2'd1:    ld_val = {b[31:24], w[31:8]};
          2'd2:    ld_val = {b[31:16], w[31:16]};
          default: ld_val = {b[31:8], w[31:24]};
        endcase
      end
      OP_SB: st_val = (w & ~(32'h000000FF << bsh)) | ({24'h000000, b[7:0]} << bsh);
      OP_SH: st_val = (w & ~(32'h0000FFFF << hsh)) | ({16'h0000, b[15:0]} << hsh);
      OP_SWL: begin
        case (lane)
          2'd0:    st_val = {w[31:8], b[31:24]};
          2'd1:    st_val = {w[31:16], b[31:16]};
          2'd2:    st_val = {w[31:24], b[31:8]};
          default: st_val = b;
        endcase
      end
      OP_SWR: begin
        case (lane)
          2'd0:    st_val = b;
          2'd1:    st_val = {b[23:0], w[7:0]};
          2'd2:    st_val = {b[15:0], w[15:0]};
          default: st_val = {b[7:0], w[23:0]};
        endcase
      end
      default: begin
        ld_val = w;
        st_val = b;
      end
    endcase
  end

endmodule

@@ rtl/mips_itype_jtype_execute.sv @@
// ----------------------------------------------------------------------------
// mips_itype_jtype_execute: MIPS32 I-type and J-type execute block
// Executes branches, jumps, immediate ALU ops, loads and stores against its
// own register file and little-endian data memory, one result per word.
//
//   channel | dir | tdata layout (lsb first)
//   in_     | in  | instruction[31:0], current_pc[63:32]
//   out_    | out | taken, target, reg_write, reg_index, reg_value,
//           |     | mem_write, mem_word_index, mem_value, unknown_op, pad
//
// A word passes three stages: register file read, operand/address stage with
// the data memory read, and merge/write-back into the output register.
// One word is accepted per cycle while nothing holds the pipeline; a word that
// reads a register written by the word just ahead of it waits in the operand
// stage until that word leaves the memory stage and writes the register file.
// After reset the data memory is cleared one word a cycle, all MEM_WORDS = 1024
// words, with in_tready low. A stalled output holds each full stage behind it.
// ----------------------------------------------------------------------------
module mips_itype_jtype_execute (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [mie_pkg::IN_W-1:0]  in_tdata,   // instruction, current_pc
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [mie_pkg::OUT_W-1:0] out_tdata   // see out_word_t, lsb first
);
  import mie_pkg::*;

  in_word_t          in_w;
  logic              in_acc;

  logic              s1_v_r;
  logic [XLEN-1:0]   s1_instr_r;
  logic [XLEN-1:0]   s1_pc_r;
  logic              s2_v_r;
  stage_t            s2_r;
  stage_t            s2_nxt;
  logic              out_v_r;
  out_word_t         out_r;
  out_word_t         out_nxt;

  logic              out_free;
  logic              s2_go;
  logic              s2_free;
  logic              hazard;
  logic              s1_go;
  logic              s1_free;

  logic [RF_DEPTH-1:0] rf_vld_r;
  logic              wb_v_r;
  logic [RF_AW-1:0]  wb_idx_r;
  logic [XLEN-1:0]   wb_val_r;
  logic              mwb_v_r;
  logic [MEM_AW-1:0] mwb_idx_r;
  logic [XLEN-1:0]   mwb_val_r;

  logic              clr_busy_r;
  logic [MEM_AW-1:0] clr_addr_r;

  logic [RF_AW-1:0]  rf_ra;
  logic [RF_AW-1:0]  rf_rb;
  logic [XLEN-1:0]   rf_a_rdata;
  logic [XLEN-1:0]   rf_b_rdata;
  logic              rf_we;

  logic              dm_we;
  logic [MEM_AW-1:0] dm_waddr;
  logic [XLEN-1:0]   dm_wdata;
  logic [XLEN-1:0]   dm_rdata;

  logic [5:0]        s1_op;
  logic [RF_AW-1:0]  s1_rs;
  logic [RF_AW-1:0]  s1_rt;
  logic [15:0]       immu;
  logic [XLEN-1:0]   imms;
  logic [XLEN-1:0]   a_op;
  logic [XLEN-1:0]   b_op;
  logic [XLEN-1:0]   ea;
  logic [XLEN-1:0]   btarget;
  logic [XLEN-1:0]   jtarget;

  logic [XLEN-1:0]   w_fwd;
  logic [XLEN-1:0]   ld_val;
  logic [XLEN-1:0]   st_val;
  logic [XLEN-1:0]   wb_value;

  assign in_w = in_word_t'(in_tdata);

  // ---------------- handshake and stage control ----------------
  assign out_free  = !out_v_r || out_tready;
  assign s2_go     = s2_v_r && out_free;
  assign s2_free   = !s2_v_r || out_free;
  assign hazard    = s1_v_r && s2_v_r && s2_r.wreg &&
                     ((s2_r.ridx == s1_rs) || (s2_r.ridx == s1_rt));
  assign s1_go     = s1_v_r && s2_free && !hazard;
  assign s1_free   = !s1_v_r || s1_go;
  assign in_tready = s1_free && !clr_busy_r;
  assign in_acc    = in_tvalid && in_tready;

  // A waiting word re-reads its operands so later writes become visible.
  always_comb begin
    if (s1_v_r && !s1_go) begin
      rf_ra = s1_rs;
      rf_rb = s1_rt;
    end else begin
      rf_ra = in_w.instruction[25:21];
      rf_rb = in_w.instruction[20:16];
    end
  end

  assign rf_we = s2_go && s2_r.wreg;

  mie_ram #(.WIDTH(XLEN), .DEPTH(RF_DEPTH)) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (s2_r.ridx),
    .wdata (wb_value),
    .re    (1'b1),
    .raddr (rf_ra),
    .rdata (rf_a_rdata)
  );

  mie_ram #(.WIDTH(XLEN), .DEPTH(RF_DEPTH)) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (s2_r.ridx),
    .wdata (wb_value),
    .re    (1'b1),
    .raddr (rf_rb),
    .rdata (rf_b_rdata)
  );

  // ---------------- operand stage ----------------
  assign s1_op = s1_instr_r[31:26];
  assign s1_rs = s1_instr_r[25:21];
  assign s1_rt = s1_instr_r[20:16];
  assign immu  = s1_instr_r[15:0];
  assign imms  = {{16{immu[15]}}, immu};

  // Entries never written read as zero; the latest write is forwarded since
  // the RAM returns old data for a write at the read edge.
  always_comb begin
    a_op = rf_vld_r[s1_rs] ? rf_a_rdata : '0;
    if (wb_v_r && (wb_idx_r == s1_rs)) begin
      a_op = wb_val_r;
    end
    b_op = rf_vld_r[s1_rt] ? rf_b_rdata : '0;
    if (wb_v_r && (wb_idx_r == s1_rt)) begin
      b_op = wb_val_r;
    end
  end

  assign ea      = a_op + imms;
  assign btarget = s1_pc_r + {imms[29:0], 2'b00};
  assign jtarget = {s1_pc_r[31:28], s1_instr_r[25:0], 2'b00};

  always_comb begin
    s2_nxt         = '0;
    s2_nxt.ridx    = s1_rt;
    s2_nxt.op      = s1_op;
    s2_nxt.lane    = ea[1:0];
    s2_nxt.widx    = ea[MEM_AW+1:2];
    s2_nxt.b       = b_op;
    s2_nxt.target  = btarget;
    unique case (s1_op)
      OP_J: begin
        s2_nxt.taken  = 1'b1;
        s2_nxt.target = jtarget;
      end
      OP_JAL: begin
        s2_nxt.taken  = 1'b1;
        s2_nxt.target = jtarget;
        s2_nxt.wreg   = 1'b1;
        s2_nxt.ridx   = RF_AW'(RF_DEPTH - 1);
        s2_nxt.rval   = s1_pc_r + 32'd4;
      end
      OP_BEQ:  s2_nxt.taken = (a_op == b_op);
      OP_BNE:  s2_nxt.taken = (a_op != b_op);
      OP_BLEZ: s2_nxt.taken = (a_op == '0) || a_op[31];
      OP_BGTZ: s2_nxt.taken = (a_op != '0) && !a_op[31];
      OP_ADDI, OP_ADDIU: begin
        s2_nxt.wreg = 1'b1;
        s2_nxt.rval = ea;
      end
      OP_SLTI: begin
        s2_nxt.wreg = 1'b1;
        s2_nxt.rval = {31'd0, ($signed(a_op) < $signed(imms))};
      end
      OP_SLTIU: begin
        s2_nxt.wreg = 1'b1;
        s2_nxt.rval = {31'd0, (a_op < imms)};
      end
      OP_ANDI: begin
        s2_nxt.wreg = 1'b1;
        s2_nxt.rval = a_op & {16'h0000, immu};
      end
      OP_ORI: begin
        s2_nxt.wreg = 1'b1;
        s2_nxt.rval = a_op | {16'h0000, immu};
      end
      OP_XORI: begin
        s2_nxt.wreg = 1'b1;
        s2_nxt.rval = a_op ^ {16'h0000, immu};
      end
      OP_LUI: begin
        s2_nxt.wreg = 1'b1;
        s2_nxt.rval = {immu, 16'h0000};
      end
      OP_LB, OP_LH, OP_LWL, OP_LW, OP_LBU, OP_LHU, OP_LWR, OP_LL: begin
        s2_nxt.wreg    = 1'b1;
        s2_nxt.is_load = 1'b1;
      end
      OP_SB, OP_SH, OP_SWL, OP_SW, OP_SWR: s2_nxt.wmem = 1'b1;
      OP_SC: begin
        s2_nxt.wmem = 1'b1;
        s2_nxt.wreg = 1'b1;
        s2_nxt.rval = 32'd1;
      end
      default: s2_nxt.unknown = 1'b1;
    endcase
    // Writes to register zero are dropped and reported as no write.
    if (!s2_nxt.wreg || (s2_nxt.ridx == '0)) begin
      s2_nxt.wreg    = 1'b0;
      s2_nxt.is_load = 1'b0;
      s2_nxt.ridx    = '0;
      s2_nxt.rval    = '0;
    end
    if (!s2_nxt.taken) begin
      s2_nxt.target = '0;
    end
  end

  // ---------------- data memory ----------------
  assign dm_we    = clr_busy_r || (s2_go && s2_r.wmem);
  assign dm_waddr = clr_busy_r ? clr_addr_r : s2_r.widx;
  assign dm_wdata = clr_busy_r ? '0 : st_val;

  mie_ram #(.WIDTH(XLEN), .DEPTH(MEM_WORDS)) u_dmem (
    .clk   (clk),
    .we    (dm_we),
    .waddr (dm_waddr),
    .wdata (dm_wdata),
    .re    (s1_go),
    .raddr (s2_nxt.widx),
    .rdata (dm_rdata)
  );

  // ---------------- memory stage ----------------
  // A store committed at the edge of this word's read is not in dm_rdata.
  assign w_fwd = (mwb_v_r && (mwb_idx_r == s2_r.widx)) ? mwb_val_r : dm_rdata;

  mie_merge u_merge (
    .op     (s2_r.op),
    .lane   (s2_r.lane),
    .w      (w_fwd),
    .b      (s2_r.b),
    .ld_val (ld_val),
    .st_val (st_val)
  );

  assign wb_value = s2_r.is_load ? ld_val : s2_r.rval;

  always_comb begin
    out_nxt                = '0;
    out_nxt.branch_taken   = s2_r.taken;
    out_nxt.branch_target  = s2_r.target;
    out_nxt.reg_write      = s2_r.wreg;
    out_nxt.reg_index      = s2_r.ridx;
    out_nxt.reg_value      = wb_value;
    out_nxt.mem_write      = s2_r.wmem;
    out_nxt.unknown_op     = s2_r.unknown;
    if (s2_r.wmem) begin
      out_nxt.mem_word_index = MIDX_W'(s2_r.widx);
      out_nxt.mem_value      = st_val;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_W'(out_r);

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      rf_vld_r   <= '0;
      wb_v_r     <= 1'b0;
      mwb_v_r    <= 1'b0;
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      if (s1_free) begin
        s1_v_r <= in_acc;
      end
      if (s2_free) begin
        s2_v_r <= s1_go;
      end
      out_v_r <= s2_go || (out_v_r && !out_tready);
      if (rf_we) begin
        rf_vld_r[s2_r.ridx] <= 1'b1;
        wb_v_r              <= 1'b1;
      end
      if (s2_go && s2_r.wmem) begin
        mwb_v_r <= 1'b1;
      end
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + MEM_AW'(1);
        if (clr_addr_r == MEM_AW'(MEM_WORDS - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_instr_r <= in_w.instruction;
      s1_pc_r    <= in_w.current_pc;
    end
    if (s1_go) begin
      s2_r <= s2_nxt;
    end
    if (s2_go) begin
      out_r <= out_nxt;
    end
    if (rf_we) begin
      wb_idx_r <= s2_r.ridx;
      wb_val_r <= wb_value;
    end
    if (s2_go && s2_r.wmem) begin
      mwb_idx_r <= s2_r.widx;
      mwb_val_r <= st_val;
    end
  end

  // ---------------- assertions ----------------
  a_no_work_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !s1_v_r && !s2_v_r)
    else $error("pipeline holds a word during the memory clearing pass");

  a_hazard_holds_word: assert property (@(posedge clk) disable iff (!rst_n)
    hazard |=> s1_v_r && $stable(s1_instr_r))
    else $error("register dependence did not hold the word in the operand stage");

  a_no_r0_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.reg_write) |-> (out_r.reg_index != '0))
    else $error("result reports a write to register zero");

  a_unknown_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.unknown_op) |->
      !out_r.reg_write && !out_r.mem_write && !out_r.branch_taken)
    else $error("unknown opcode changed state");

endmodule
